// ----- rtl/core/cmf_pkg.sv -----
// shared types and constants of the can frame queue
package cmf_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ID_W          = 29;
   localparam int PAYLOAD_W     = 64;
   localparam int DLC_W         = 4;
   localparam int LEVEL_W       = 5;
   localparam logic [DLC_W-1:0] MAX_DLC = 4'd8;

   typedef enum logic [2:0] {
      MODE_PUSH    = 3'd0,
      MODE_STAGE   = 3'd1,
      MODE_COMMIT  = 3'd2,
      MODE_POP     = 3'd3,
      MODE_PEEK    = 3'd4,
      MODE_RELEASE = 3'd5
   } mode_type;

   typedef struct packed {
      logic [2:0]           mode;
      logic [ID_W-1:0]      msg_id;
      logic [PAYLOAD_W-1:0] payload;
      logic [3:0]           byte_count;
      logic [3:0]           offset;
      logic [4:0]           amount;
   } req_type;

   typedef struct packed {
      logic                 error;
      logic [ID_W-1:0]      out_id;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [DLC_W-1:0]     out_dlc;
      logic [LEVEL_W-1:0]   level;
      logic                 empty_res;
      logic                 full_res;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]      id;
      logic [DLC_W-1:0]     dlc;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // result status that rides along with a pending memory read
   typedef struct packed {
      logic               error;
      logic               rd_hit;
      logic [LEVEL_W-1:0] level;
      logic               empty_res;
      logic               full_res;
   } meta_type;

endpackage

// ----- rtl/core/cmf_ram.sv -----
// generic ram with separate write and read addresses and registered read
module cmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/cmf_ctrl.sv -----
// head and fill bookkeeping, operation decode and memory address generation
module cmf_ctrl #(
   parameter int DEPTH = cmf_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmf_pkg::req_type         req,
   input  logic                     accept,
   output logic                     mem_we,
   output logic                     mem_re,
   output logic [$clog2(DEPTH)-1:0] mem_addr,
   output cmf_pkg::entry_type       mem_wdata,
   output cmf_pkg::meta_type        meta
);

   import cmf_pkg::*;

   localparam int IW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SUM_W = CW + 1;
   localparam int AMT_W = ((CW > 5) ? CW : 5) + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [IW-1:0] tail;
   logic [IW-1:0] off_mod [16];
   logic [AMT_W-1:0] commit_sum;
   logic [DLC_W-1:0] dlc_sat;
   logic [PAYLOAD_W-1:0] payload_kept;

   // offset folded into the ring, worked out at elaboration
   for (genvar g = 0; g < 16; g++) begin : g_off
      assign off_mod[g] = IW'(g % DEPTH);
   end

   // a < depth, b <= depth: one compare and subtract wraps it
   function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(b);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return IW'(s);
   endfunction

   always_comb begin
      dlc_sat = (req.byte_count > MAX_DLC) ? MAX_DLC : req.byte_count;
      for (int i = 0; i < 8; i++) begin
         payload_kept[i*8 +: 8] = (4'(i) < dlc_sat) ? req.payload[i*8 +: 8] : 8'h00;
      end
      mem_wdata.id      = req.msg_id;
      mem_wdata.dlc     = dlc_sat;
      mem_wdata.payload = payload_kept;
   end

   assign tail       = wrap_add(head_ff, fill_ff);
   assign commit_sum = AMT_W'(fill_ff) + AMT_W'(req.amount);

   always_comb begin
      head_in     = head_ff;
      fill_in     = fill_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = head_ff;
      meta.error  = 1'b1;
      meta.rd_hit = 1'b0;
      unique case (req.mode)
         MODE_PUSH: begin
            if (fill_ff != DEPTH_C) begin
               mem_we     = 1'b1;
               mem_addr   = tail;
               fill_in    = fill_ff + CW'(1);
               meta.error = 1'b0;
            end
         end
         MODE_STAGE: begin
            if (fill_ff != DEPTH_C) begin
               mem_we     = 1'b1;
               mem_addr   = wrap_add(tail, CW'(off_mod[req.offset]));
               meta.error = 1'b0;
            end
         end
         MODE_COMMIT: begin
            if (commit_sum <= AMT_W'(DEPTH)) begin
               fill_in    = CW'(commit_sum);
               meta.error = 1'b0;
            end
         end
         MODE_POP: begin
            if (fill_ff != '0) begin
               mem_re      = 1'b1;
               head_in     = wrap_add(head_ff, CW'(1));
               fill_in     = fill_ff - CW'(1);
               meta.error  = 1'b0;
               meta.rd_hit = 1'b1;
            end
         end
         MODE_PEEK: begin
            if (fill_ff != '0) begin
               mem_re      = 1'b1;
               mem_addr    = wrap_add(head_ff, CW'(off_mod[req.offset]));
               meta.error  = 1'b0;
               meta.rd_hit = 1'b1;
            end
         end
         MODE_RELEASE: begin
            if (AMT_W'(req.amount) <= AMT_W'(fill_ff)) begin
               head_in    = wrap_add(head_ff, CW'(req.amount));
               fill_in    = fill_ff - CW'(req.amount);
               meta.error = 1'b0;
            end
         end
         default: begin
            meta.error = 1'b1;
         end
      endcase
      meta.level     = LEVEL_W'(fill_in);
      meta.empty_res = (fill_in == '0);
      meta.full_res  = (fill_in == DEPTH_C);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ----- rtl/core/can_message_fifo.sv -----
// top level of the can frame queue: request stage, frame memory and response register
//
// usage
//  - req channel: one transaction carries one operation (push, staged write, commit,
//    pop, peek, release) with the frame fields and offset/amount operands
//  - rsp channel: exactly one transaction per request, in request order, with error,
//    frame read (zero unless a pop or peek succeeds), level and empty/full flags
//  - head and fill level update at the edge that accepts the request, so the next
//    request sees them at once; writes land in the frame memory at that same edge
//  - response path: the request stage, then the response register
//  - throughput: one transaction per cycle while the receiver takes responses, set by
//    the single memory access each operation makes and the registered read of the frame memory
//  - receiver stall: the request stage holds the operation and its read data while
//    the response register waits; req_ready drops only once both are occupied
//  - reset: head and level clear to zero, both stages empty; the frame memory is
//    not cleared and a slot never written reads as unknown data
module can_message_fifo #(
   parameter int DEPTH = cmf_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cmf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cmf_pkg::rsp_type rsp_data
);

   import cmf_pkg::*;

   localparam int IW = $clog2(DEPTH);

   logic      accept;
   logic      s1_move;
   logic      mem_we;
   logic      mem_re;
   logic [IW-1:0] mem_addr;
   entry_type mem_wdata;
   entry_type mem_rdata;
   meta_type  meta;

   // request stage: status of the operation whose read data is in the ram output
   logic     s1_valid_ff;
   meta_type s1_meta_ff;

   // response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   cmf_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .accept    (accept),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .meta      (meta)
   );

   // each transaction makes at most one access and reads only after earlier writes
   // have landed, so no forwarding path is needed
   cmf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept && mem_we),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .rd_en   (accept && mem_re),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   // frame fields only on a successful pop or peek
   always_comb begin
      rsp_in.error       = s1_meta_ff.error;
      rsp_in.out_id      = s1_meta_ff.rd_hit ? mem_rdata.id : '0;
      rsp_in.out_payload = s1_meta_ff.rd_hit ? mem_rdata.payload : '0;
      rsp_in.out_dlc     = s1_meta_ff.rd_hit ? mem_rdata.dlc : '0;
      rsp_in.level       = s1_meta_ff.level;
      rsp_in.empty_res   = s1_meta_ff.empty_res;
      rsp_in.full_res    = s1_meta_ff.full_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         s1_meta_ff <= meta;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a stalled request stage keeps its status
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_meta_ff))
      else $error("request stage lost or changed a stalled transaction");

   // refused operations carry no frame
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error |->
         rsp_ff.out_id == '0 && rsp_ff.out_dlc == '0 && rsp_ff.out_payload == '0)
      else $error("refused transaction returned frame data");

   // empty and full never reported together
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.empty_res && rsp_ff.full_res))
      else $error("empty and full flagged together");
`endif

endmodule
